FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define KD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define KD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/kdse_pkg.sv
// Shared types and constants for the k distinct sum enumerator.
package kdse_pkg;

   localparam int DEF_VALUE_BITS = 10;
   localparam int DEF_MAX_TERMS  = 5;
   localparam int GOAL_BITS      = 13;
   localparam int TERM_BITS      = 10;
   localparam int OUT_TERMS      = 5;
   localparam int TC_BITS        = 3;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [TC_BITS-1:0] TC_RESET = 3'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TERM_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_LOW  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_HIGH = 2'd2;

   typedef struct packed {
      logic                 mode;
      logic [GOAL_BITS-1:0] target_sum;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic                 exhausted;
      logic [TERM_BITS-1:0] term_a;
      logic [TERM_BITS-1:0] term_b;
      logic [TERM_BITS-1:0] term_c;
      logic [TERM_BITS-1:0] term_d;
      logic [TERM_BITS-1:0] term_e;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic start;
      logic adv_init;
      logic adv_sel;
      logic eval;
      logic pos_wr;
      logic descend;
      logic ascend;
      logic out_load;
      logic out_found;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic ok;
      logic at_last;
      logic at_first;
   } status_type;

endpackage

FILE: src/kdse_ctrl.sv
// Sequencing state machine: walks the search levels and hands results out.
module kdse_ctrl import kdse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  logic       req_mode,
   input  logic       csr_hit,
   input  logic       rsp_ready,
   input  status_type status,
   output logic       req_ready,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       fill_ff, fill_in;
   logic       result_ff, result_in;
   logic       searching_ff, searching_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      result_in    = result_ff;
      searching_in = searching_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (!req_mode) begin
                  cmd.start = 1'b1;
                  fill_in   = 1'b1;
                  state_in  = S_EVAL;
               end else if (searching_ff) begin
                  cmd.adv_init = 1'b1;
                  fill_in      = 1'b0;
                  state_in     = S_EVAL;
               end else begin
                  result_in = 1'b0;
                  state_in  = S_RESP;
               end
            end
         end
         S_EVAL: begin
            cmd.eval    = 1'b1;
            cmd.adv_sel = !fill_ff;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (status.ok) begin
               cmd.pos_wr = 1'b1;
               if (status.at_last) begin
                  result_in = 1'b1;
                  state_in  = S_RESP;
               end else begin
                  cmd.descend = 1'b1;
                  fill_in     = 1'b1;
                  state_in    = S_EVAL;
               end
            end else if (fill_ff || status.at_first) begin
               result_in = 1'b0;
               state_in  = S_RESP;
            end else begin
               cmd.ascend = 1'b1;
               state_in   = S_EVAL;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load  = 1'b1;
               cmd.out_found = result_ff;
               searching_in  = result_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_hit) begin
         searching_in = 1'b0;
      end
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= 1'b0;
         result_ff    <= 1'b0;
         searching_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         result_ff    <= result_in;
         searching_ff <= searching_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/kdse_datapath.sv
// Position registers, remaining-sum arithmetic, config registers and result register.
module kdse_datapath import kdse_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int MAX_TERMS  = DEF_MAX_TERMS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_hit,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [VALUE_BITS-1:0]   csr_wdata,
   input  req_type                 req_data,
   input  cmd_type                 cmd,
   output status_type              status,
   output rsp_type                 rsp_data
);

   localparam int LVL_W = $clog2(MAX_TERMS);
   localparam int REM_W = ((GOAL_BITS > VALUE_BITS + 4) ? GOAL_BITS : VALUE_BITS + 4) + 5;
   localparam int VIS   = (MAX_TERMS < OUT_TERMS) ? MAX_TERMS : OUT_TERMS;

   logic [TC_BITS-1:0]    term_count_ff;
   logic [VALUE_BITS-1:0] lo_ff, hi_ff;
   logic [VALUE_BITS-1:0] pos_ff [MAX_TERMS];
   logic [LVL_W-1:0]      lvl_ff;
   logic signed [REM_W-1:0] rem_ff;
   logic signed [REM_W-1:0] cand_ff, cand_in;
   logic                  okpre_ff, okpre_in;
   rsp_type               rsp_ff, rsp_in;

   logic [LVL_W-1:0]      n_last, r_val, prev_idx;
   logic [VALUE_BITS:0]   m_val, mm_val;
   logic [REM_W-1:0]      r_w, tri_lo_w, tri_hi_w;
   logic signed [REM_W-1:0] r_s, r1_s, hi_s, mm_s, maxrest_s, c_s, prod_s;
   logic                  ok;
   logic [TERM_BITS-1:0]  terms [OUT_TERMS];

   // Clamp the term count into the supported span.
   always_comb begin
      if (term_count_ff < 3'd2) begin
         n_last = LVL_W'(1);
      end else if (int'(term_count_ff) > MAX_TERMS) begin
         n_last = LVL_W'(MAX_TERMS - 1);
      end else begin
         n_last = LVL_W'(term_count_ff - 3'd1);
      end
   end

   assign r_val    = n_last - lvl_ff;
   assign prev_idx = (lvl_ff == '0) ? '0 : lvl_ff - 1'b1;

   // Lower bound for this level.
   always_comb begin
      if (cmd.adv_sel) begin
         m_val = {1'b0, pos_ff[lvl_ff]} + 1'b1;
      end else if (lvl_ff == '0) begin
         m_val = {1'b0, lo_ff};
      end else begin
         m_val = {1'b0, pos_ff[prev_idx]} + 1'b1;
      end
      mm_val = (m_val > {1'b0, lo_ff}) ? m_val : {1'b0, lo_ff};
   end

   assign r_w       = REM_W'(r_val);
   assign tri_lo_w  = (r_w * (r_w - 1'b1)) >> 1;
   assign tri_hi_w  = (r_w * (r_w + 1'b1)) >> 1;
   assign r_s       = $signed(r_w);
   assign r1_s      = $signed(r_w + 1'b1);
   assign hi_s      = $signed(REM_W'(hi_ff));
   assign mm_s      = $signed(REM_W'(mm_val));
   assign maxrest_s = r_s * hi_s - $signed(tri_lo_w);
   assign c_s       = rem_ff - maxrest_s;

   // First half of the level test: smallest candidate that can still complete.
   always_comb begin
      if (r_val == '0) begin
         cand_in  = rem_ff;
         okpre_in = (rem_ff >= mm_s) && (rem_ff <= hi_s);
      end else begin
         cand_in  = (mm_s > c_s) ? mm_s : c_s;
         okpre_in = 1'b1;
      end
   end

   // Second half: room above and minimum completion sum.
   assign prod_s = r1_s * cand_ff;
   assign ok     = okpre_ff && ((r_val == '0) ||
                   ((cand_ff + r_s <= hi_s) && (prod_s + $signed(tri_hi_w) <= rem_ff)));

   assign status.ok       = ok;
   assign status.at_last  = (lvl_ff == n_last);
   assign status.at_first = (lvl_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TC_RESET;
         lo_ff         <= '0;
         hi_ff         <= '1;
      end else if (csr_hit) begin
         case (csr_index)
            CSR_TERM_COUNT: term_count_ff <= csr_wdata[TC_BITS-1:0];
            CSR_RANGE_LOW:  lo_ff         <= csr_wdata;
            CSR_RANGE_HIGH: hi_ff         <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         cand_ff  <= cand_in;
         okpre_ff <= okpre_in;
      end
      if (cmd.pos_wr) begin
         pos_ff[lvl_ff] <= cand_ff[VALUE_BITS-1:0];
      end
      if (cmd.start) begin
         rem_ff <= $signed(REM_W'(req_data.target_sum));
         lvl_ff <= '0;
      end else if (cmd.adv_init) begin
         lvl_ff <= n_last;
      end else if (cmd.descend) begin
         rem_ff <= rem_ff - cand_ff;
         lvl_ff <= lvl_ff + 1'b1;
      end else if (cmd.ascend) begin
         rem_ff <= rem_ff + $signed(REM_W'(pos_ff[prev_idx]));
         lvl_ff <= prev_idx;
      end
   end

   // Result beat: terms beyond the active count, and all terms of an exhausted beat, read as zero.
   always_comb begin
      for (int j = 0; j < OUT_TERMS; j++) begin
         terms[j] = '0;
      end
      for (int j = 0; j < VIS; j++) begin
         if (cmd.out_found && (LVL_W'(j) <= n_last)) begin
            terms[j] = TERM_BITS'(pos_ff[j]);
         end
      end
      rsp_in.found     = cmd.out_found;
      rsp_in.exhausted = !cmd.out_found;
      rsp_in.term_a    = terms[0];
      rsp_in.term_b    = terms[1];
      rsp_in.term_c    = terms[2];
      rsp_in.term_d    = terms[3];
      rsp_in.term_e    = terms[4];
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: src/k_distinct_sum_enumerator.sv
// Each level visit runs a candidate state, then a check state; a start visits up to the
// clamped term count of levels, an advance up to twice that less one (climb, then refill),
// none unsearched. The result beat loads from the response state after the last visit.
// One request in flight: the next is taken once the result beat loads, which waits while
// the result register still holds an untaken beat.
// Reset (synchronous, active high) restores register defaults and ends any search.
module k_distinct_sum_enumerator import kdse_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int MAX_TERMS  = DEF_MAX_TERMS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [VALUE_BITS-1:0]   csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       req_fire;
   logic       csr_hit;

   // The user must make register writes land only while idle; the block does not enforce it. The port never stalls.
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   // A write to a listed register ends the active search; other indexes drop.
   assign csr_hit = csr_valid && ((csr_index == CSR_TERM_COUNT) ||
                                  (csr_index == CSR_RANGE_LOW) ||
                                  (csr_index == CSR_RANGE_HIGH));

   // Controller: owns the handshake, the search flag and the level walk.
   kdse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_mode  (req_data.mode),
      .csr_hit   (csr_hit),
      .rsp_ready (rsp_ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Datapath: positions, remaining sum, pruning arithmetic and the result beat.
   kdse_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_TERMS  (MAX_TERMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_hit   (csr_hit),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/kdse_checker.sv
// Port-level checks for the enumerator, bound to the top level.
`include "assert_macros.svh"

module kdse_checker import kdse_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic rsp_stall;
   logic terms_clear;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign terms_clear = (rsp_data.term_a == '0) && (rsp_data.term_b == '0) &&
                        (rsp_data.term_c == '0) && (rsp_data.term_d == '0) &&
                        (rsp_data.term_e == '0);

   `KD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "beat right after reset")
   `KD_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_valid && $stable(rsp_data)), "held beat")
   `KD_ASSERT(a_one_in_flight, clock, reset, (req_valid && req_ready) |=> !req_ready, "second req")
   `KD_ASSERT(a_exhausted_clean, clock, reset, rsp_valid && rsp_data.exhausted |-> !rsp_data.found, "flags")
   `KD_ASSERT(a_exhausted_terms, clock, reset, (rsp_valid && rsp_data.exhausted) |-> terms_clear, "terms")

endmodule

bind k_distinct_sum_enumerator kdse_checker u_checker (.*);
